@@ src/btce_pkg.sv @@
package btce_pkg;

  localparam int CW          = 16;
  localparam int DIM_W       = 15;
  localparam int PAD_W       = 10;
  localparam int SLOT_W      = 6;
  localparam int OBJ_DEF     = 32;
  localparam int INT_DEF     = 32;
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int EDGE_W      = CW + 3;

  localparam logic [2:0] MODE_WRITE  = 3'd0;
  localparam logic [2:0] MODE_CLEAR  = 3'd1;
  localparam logic [2:0] MODE_FIRST  = 3'd2;
  localparam logic [2:0] MODE_MOVE   = 3'd3;
  localparam logic [2:0] MODE_GATHER = 3'd4;

  typedef struct packed {
    logic [2:0]              mode;
    logic [SLOT_W-1:0]       slot;
    logic                    flag;
    logic signed [CW-1:0]    box_left;
    logic signed [CW-1:0]    box_top;
    logic [DIM_W-1:0]        box_width;
    logic [DIM_W-1:0]        box_height;
    logic signed [CW-1:0]    pos_x;
    logic signed [CW-1:0]    pos_y;
    logic signed [CW-1:0]    next_x;
    logic signed [CW-1:0]    next_y;
    logic [PAD_W-1:0]        padding;
  } in_req_t;

  typedef struct packed {
    logic                    hit;
    logic [SLOT_W-1:0]       hit_slot;
    logic signed [CW-1:0]    res_x;
    logic signed [CW-1:0]    res_y;
    logic                    last;
  } out_res_t;

  typedef struct packed {
    logic                    valid;
    logic                    persist;
    logic signed [CW-1:0]    left;
    logic signed [CW-1:0]    top;
    logic [DIM_W-1:0]        w;
    logic [DIM_W-1:0]        h;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic clr;
    logic wr;
  } cell_ctrl_t;

  // padded query: corner may leave the coordinate range, size grows by twice the margin
  typedef struct packed {
    logic signed [CW:0]      left;
    logic signed [CW:0]      top;
    logic [DIM_W:0]          w;
    logic [DIM_W:0]          h;
  } query_t;

endpackage

@@ src/btce_cell.sv @@
module btce_cell
  import btce_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  entry_t     shift_in,
  input  entry_t     wr_data,
  output entry_t     q
);

  entry_t ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else if (ctrl.clr) begin
      ent_r.valid <= 1'b0;
    end else if (ctrl.wr) begin
      ent_r.valid <= wr_data.valid;
    end else if (ctrl.shift) begin
      ent_r.valid <= shift_in.valid;
    end
    if (ctrl.wr) begin
      ent_r.persist <= wr_data.persist;
      ent_r.left    <= wr_data.left;
      ent_r.top     <= wr_data.top;
      ent_r.w       <= wr_data.w;
      ent_r.h       <= wr_data.h;
    end else if (ctrl.shift) begin
      ent_r.persist <= shift_in.persist;
      ent_r.left    <= shift_in.left;
      ent_r.top     <= shift_in.top;
      ent_r.w       <= shift_in.w;
      ent_r.h       <= shift_in.h;
    end
  end

  assign q = ent_r;

endmodule

@@ src/btce_probe.sv @@
module btce_probe
  import btce_pkg::*;
(
  input  query_t qry,
  input  entry_t ent,
  output logic   overlap
);

  logic signed [EDGE_W-1:0] q_l, q_r, q_t, q_b, e_l, e_r, e_t, e_b;

  always_comb begin
    q_l = EDGE_W'(qry.left);
    q_t = EDGE_W'(qry.top);
    q_r = q_l + $signed(EDGE_W'(qry.w));
    q_b = q_t + $signed(EDGE_W'(qry.h));
    e_l = EDGE_W'(ent.left);
    e_t = EDGE_W'(ent.top);
    e_r = e_l + $signed(EDGE_W'(ent.w));
    e_b = e_t + $signed(EDGE_W'(ent.h));
    overlap = (e_l <= q_r) && (e_r >= q_l) && (e_t <= q_b) && (e_b >= q_t);
  end

endmodule

@@ src/box_table_collision_engine.sv @@
// channel  | ports                   | handshake
// request  | start, busy, in_req     | taken when start && !busy
// result   | out_valid, out_res      | one-cycle strobe, no back-pressure
// Write, clear and unknown modes: result in the cycle after the request.
// Queries rotate the entry ring once past a single probe; a move query holds the ring
// on a hit while it steps its offset toward zero, and the result is emitted from S_FLUSH.
// Gather emits each hit as soon as the next one is found; the last follows the scan.
// Reset (synchronous, rst_n low) clears all entry valid bits and the sequencer.
// busy stays high from a query request until its final result is driven.
module box_table_collision_engine
  import btce_pkg::*;
#(
  parameter int OBJ_SLOTS = OBJ_DEF,
  parameter int INT_SLOTS = INT_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_res_t out_res
);

  localparam int TOTAL = OBJ_SLOTS + INT_SLOTS;
  localparam int IDX_W = $clog2(TOTAL);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FLUSH} state_t;

  state_t               state_r, state_nxt;
  logic [2:0]           mode_r, mode_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic                 flag_r, flag_nxt;
  query_t               qry_r, qry_nxt;
  logic signed [CW-1:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [CW:0]   ox_r, ox_nxt, oy_r, oy_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 found_r, found_nxt;
  logic [SLOT_W-1:0]    hs_r, hs_nxt;
  logic [CNT_W-1:0]     gcnt_r, gcnt_nxt;
  logic                 pend_r, pend_nxt;
  logic [SLOT_W-1:0]    pslot_r, pslot_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_res_t             out_res_r, out_res_nxt;

  entry_t               cq [TOTAL];
  entry_t               head, wb, wr_ent;
  logic                 shift_c, clr_c, inval_c;
  logic [TOTAL-1:0]     wr_c;
  query_t               probe_q;
  logic                 ovl;
  logic signed [CW-1:0] mx, my;
  logic signed [CW:0]   tzx, tzy;
  logic                 querier, cand, act;

  assign head = cq[0];

  always_comb begin
    wb = head;
    if (inval_c) begin
      wb.valid = 1'b0;
    end
    wr_ent.valid   = 1'b1;
    wr_ent.persist = in_req.flag;
    wr_ent.left    = in_req.box_left + in_req.pos_x;
    wr_ent.top     = in_req.box_top + in_req.pos_y;
    wr_ent.w       = in_req.box_width;
    wr_ent.h       = in_req.box_height;
  end

  for (genvar k = 0; k < TOTAL; k++) begin : g_cell
    cell_ctrl_t ctl;
    entry_t     sin;
    assign ctl.shift = shift_c;
    assign ctl.clr   = clr_c;
    assign ctl.wr    = wr_c[k];
    if (k == TOTAL - 1) begin : g_tail
      assign sin = wb;
    end else begin : g_mid
      assign sin = cq[k+1];
    end
    btce_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctl),
      .shift_in (sin),
      .wr_data  (wr_ent),
      .q        (cq[k])
    );
  end

  always_comb begin
    mx = qry_r.left[CW-1:0] + ox_r[CW-1:0];
    my = qry_r.top[CW-1:0] + oy_r[CW-1:0];
    probe_q = qry_r;
    if (mode_r == MODE_MOVE) begin
      probe_q.left = (CW+1)'(mx);
      probe_q.top  = (CW+1)'(my);
    end
  end

  btce_probe u_probe (
    .qry     (probe_q),
    .ent     (head),
    .overlap (ovl)
  );

  always_comb begin
    tzx = ox_r;
    tzy = oy_r;
    if (ox_r > 0) begin
      tzx = ox_r - (CW+1)'(1);
    end else if (ox_r < 0) begin
      tzx = ox_r + (CW+1)'(1);
    end
    if (oy_r > 0) begin
      tzy = oy_r - (CW+1)'(1);
    end else if (oy_r < 0) begin
      tzy = oy_r + (CW+1)'(1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    slot_nxt      = slot_r;
    flag_nxt      = flag_r;
    qry_nxt       = qry_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    hs_nxt        = hs_r;
    gcnt_nxt      = gcnt_r;
    pend_nxt      = pend_r;
    pslot_nxt     = pslot_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = '0;
    shift_c       = 1'b0;
    clr_c         = 1'b0;
    inval_c       = 1'b0;
    wr_c          = '0;
    querier       = flag_r && (32'(idx_r) == 32'(slot_r));
    cand          = head.valid && !querier && ovl;
    act           = (32'(idx_r) >= OBJ_SLOTS) && head.valid && ovl
                    && (32'(gcnt_r) < MAX_RESULTS);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          priority if (in_req.mode == MODE_WRITE) begin
            for (int k = 0; k < TOTAL; k++) begin
              wr_c[k] = (32'(in_req.slot) == k);
            end
            out_valid_nxt    = 1'b1;
            out_res_nxt.last = 1'b1;
          end else if (in_req.mode == MODE_CLEAR) begin
            clr_c            = 1'b1;
            out_valid_nxt    = 1'b1;
            out_res_nxt.last = 1'b1;
          end else if (in_req.mode == MODE_FIRST || in_req.mode == MODE_MOVE
                       || in_req.mode == MODE_GATHER) begin
            state_nxt = S_SCAN;
            mode_nxt  = in_req.mode;
            slot_nxt  = in_req.slot;
            flag_nxt  = in_req.flag;
            px_nxt    = in_req.pos_x;
            py_nxt    = in_req.pos_y;
            ox_nxt    = (CW+1)'(in_req.next_x) - (CW+1)'(in_req.pos_x);
            oy_nxt    = (CW+1)'(in_req.next_y) - (CW+1)'(in_req.pos_y);
            idx_nxt   = '0;
            found_nxt = 1'b0;
            hs_nxt    = '0;
            gcnt_nxt  = '0;
            pend_nxt  = 1'b0;
            if (in_req.mode == MODE_GATHER) begin
              qry_nxt.left = (CW+1)'(in_req.box_left) - (CW+1)'(in_req.padding);
              qry_nxt.top  = (CW+1)'(in_req.box_top) - (CW+1)'(in_req.padding);
              qry_nxt.w    = (DIM_W+1)'(in_req.box_width)
                             + (DIM_W+1)'({in_req.padding, 1'b0});
              qry_nxt.h    = (DIM_W+1)'(in_req.box_height)
                             + (DIM_W+1)'({in_req.padding, 1'b0});
            end else begin
              qry_nxt.left = (CW+1)'(CW'(in_req.box_left + in_req.pos_x));
              qry_nxt.top  = (CW+1)'(CW'(in_req.box_top + in_req.pos_y));
              qry_nxt.w    = (DIM_W+1)'(in_req.box_width);
              qry_nxt.h    = (DIM_W+1)'(in_req.box_height);
            end
          end else begin
            out_valid_nxt    = 1'b1;
            out_res_nxt.last = 1'b1;
          end
        end
      end
      S_SCAN: begin
        shift_c = 1'b1;
        if (mode_r == MODE_FIRST) begin
          if (cand && !found_r) begin
            found_nxt = 1'b1;
            hs_nxt    = SLOT_W'(idx_r);
          end
        end else if (mode_r == MODE_MOVE) begin
          if (cand) begin
            if (!found_r) begin
              found_nxt = 1'b1;
              hs_nxt    = SLOT_W'(idx_r);
            end
            if (ox_r != 0 || oy_r != 0) begin
              ox_nxt  = tzx;
              oy_nxt  = tzy;
              shift_c = (tzx == 0) && (tzy == 0);
            end
          end
        end else if (act) begin
          gcnt_nxt  = gcnt_r + 1'b1;
          inval_c   = !head.persist;
          pend_nxt  = 1'b1;
          pslot_nxt = SLOT_W'(idx_r);
          if (pend_r) begin
            out_valid_nxt        = 1'b1;
            out_res_nxt.hit      = 1'b1;
            out_res_nxt.hit_slot = pslot_r;
          end
        end
        if (shift_c) begin
          idx_nxt = idx_r + 1'b1;
          if (32'(idx_r) == TOTAL - 1) begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        state_nxt        = S_IDLE;
        out_valid_nxt    = 1'b1;
        out_res_nxt.last = 1'b1;
        if (mode_r == MODE_GATHER) begin
          out_res_nxt.hit      = pend_r;
          out_res_nxt.hit_slot = pend_r ? pslot_r : '0;
        end else begin
          out_res_nxt.hit      = found_r;
          out_res_nxt.hit_slot = found_r ? hs_r : '0;
          if (mode_r == MODE_MOVE) begin
            out_res_nxt.res_x = px_r + ox_r[CW-1:0];
            out_res_nxt.res_y = py_r + oy_r[CW-1:0];
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      gcnt_r      <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      gcnt_r      <= gcnt_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      idx_r       <= idx_nxt;
    end
    mode_r    <= mode_nxt;
    slot_r    <= slot_nxt;
    flag_r    <= flag_nxt;
    qry_r     <= qry_nxt;
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    ox_r      <= ox_nxt;
    oy_r      <= oy_nxt;
    hs_r      <= hs_nxt;
    pslot_r   <= pslot_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef SYNTH
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FLUSH |=> out_valid && out_res.last)
    else $error("flush without final result");
  a_miss_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.hit |-> out_res.hit_slot == '0)
    else $error("slot reported without hit");
  a_mid_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.last |-> out_res.hit && mode_r == MODE_GATHER)
    else $error("non-final result outside gather");
  a_gather_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(gcnt_r) <= MAX_RESULTS)
    else $error("gather count overrun");
  a_scan_realign: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> idx_r == '0)
    else $error("ring not realigned");
`endif

endmodule
